// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the ICMP echo responder.
// No dependencies; synthesis builds define SYNTHESIS to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
// Condition that must never be true on a rising edge of clk.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== design/icmp_er_pkg.sv =====
// Shared types, codes and helpers of the ICMP echo responder.
// No dependencies.
`default_nettype none

package icmp_er_pkg;

  localparam int MAX_BYTES_DEF = 1024;
  localparam int MIN_BYTES     = 8;
  localparam int LEN_W         = 11;

  localparam logic [7:0]  ECHO_REQUEST  = 8'd8;
  localparam logic [7:0]  ECHO_CODE     = 8'd0;
  localparam logic [15:0] CHECKSUM_GOOD = 16'hFFFF;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_BYTE    = 1'b1;

  typedef enum logic [1:0] {
    VERD_READY   = 2'd0,
    VERD_BAD_LEN = 2'd1,
    VERD_BAD_SUM = 2'd2,
    VERD_UNSUPP  = 2'd3
  } verdict_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== design/icmp_er_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module icmp_er_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/icmp_echo_responder.sv =====
// ICMP echo responder top level: load path, verdict, reply fetch.
// Depends on icmp_er_pkg, icmp_er_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A message is loaded one byte per transaction (req_type load) and one
// transaction on the output side comes back for the byte flagged
// last_byte: the verdict. Unless the input side is held off, loads run at
// one byte per cycle; the byte goes straight into the message RAM and the
// running one's-complement sums (whole message and body from offset 4), so
// the verdict is ready in the output register the cycle after the last byte.
// After a ready verdict the reply is fetched one byte per transaction
// (req_type fetch), each through the registered read of the message RAM.
// Type and code read back as zero, bytes 2 and 3 carry the new checksum and
// the rest is copied from the request. A load while a reply is pending
// drops that reply and starts a new message; a fetch with nothing pending
// is accepted and gives no transaction. The input side is held off only
// while a result sits in the output register untaken or a RAM read is in
// flight. The message RAM needs no clearing after reset: only bytes that
// were written are ever read back.
module icmp_echo_responder
  import icmp_er_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] sender_ip,
  input  wire logic [31:0] receiver_ip,
  input  wire logic [47:0] sender_mac,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [1:0]       verdict,
  output logic [LEN_W-1:0] reply_length,
  output logic [7:0]       reply_byte,
  output logic             reply_end,
  output logic [31:0]      reply_to_ip,
  output logic [31:0]      reply_from_ip,
  output logic [47:0]      reply_to_mac
);

  localparam int CW = $clog2(MAX_BYTES + 1);  // byte count, up to MAX_BYTES
  localparam int AW = $clog2(MAX_BYTES);      // RAM address

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t        state;
  logic [CW-1:0] byte_count;
  logic          overflow;
  logic [15:0]   sum_all;
  logic [15:0]   sum_body;
  logic [7:0]    high_hold;
  logic          reply_pending;
  logic [CW-1:0] read_pointer;
  logic [15:0]   reply_checksum;
  logic [31:0]   hold_to_ip;
  logic [31:0]   hold_from_ip;
  logic [47:0]   hold_to_mac;
  logic [7:0]    msg_type;
  logic [7:0]    msg_code;
  logic [CW-1:0] fetch_ptr;   // pointer of the fetch whose RAM read is in flight
  logic          fetch_end;

  logic          in_fire;
  logic          load_fire;
  logic          fetch_fire;
  logic [CW-1:0] pos;
  logic          store_ok;
  logic [CW-1:0] count_next;
  logic          overflow_next;
  logic [15:0]   word;
  logic          add_en;
  logic [15:0]   sum_all_next;
  logic [15:0]   sum_body_next;
  logic [7:0]    high_hold_next;
  verdict_t      verdict_next;
  logic          ptr_at_end;
  logic [7:0]    ram_rd_data;
  logic [7:0]    fetch_byte;

  // Input is taken while no RAM read is in flight and the output register
  // is free or being emptied in this cycle.
  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (req_type == REQ_LOAD);
  assign fetch_fire = in_fire && (req_type == REQ_FETCH) && reply_pending;

  // Load path. A pending reply is abandoned, so the new message starts at 0.
  assign pos           = reply_pending ? '0 : byte_count;
  assign store_ok      = pos < CW'(MAX_BYTES);
  assign count_next    = store_ok ? pos + CW'(1) : pos;
  assign overflow_next = overflow || !store_ok;

  // Even offset: high byte of a word, summed only when it is the odd last
  // byte (padded low with zero). Odd offset: completes the word.
  assign word           = pos[0] ? {high_hold, data_byte} : {data_byte, 8'h00};
  assign add_en         = pos[0] || last_byte;
  assign sum_all_next   = add_en ? oc_add(sum_all, word) : sum_all;
  assign sum_body_next  = (add_en && (pos >= CW'(4))) ? oc_add(sum_body, word) : sum_body;
  assign high_hold_next = pos[0] ? high_hold : data_byte;

  always_comb begin
    priority if (overflow_next || (count_next < CW'(MIN_BYTES))) begin
      verdict_next = VERD_BAD_LEN;
    end else if (sum_all_next != CHECKSUM_GOOD) begin
      verdict_next = VERD_BAD_SUM;
    end else if ((msg_type != ECHO_REQUEST) || (msg_code != ECHO_CODE)) begin
      verdict_next = VERD_UNSUPP;
    end else begin
      verdict_next = VERD_READY;
    end
  end

  assign ptr_at_end = ((CW+1)'(read_pointer) + (CW+1)'(1)) >= (CW+1)'(byte_count);

  // Reply byte: zeroed type and code, new checksum, then the stored message.
  always_comb begin
    priority if (fetch_ptr < CW'(2)) begin
      fetch_byte = 8'h00;
    end else if (fetch_ptr == CW'(2)) begin
      fetch_byte = reply_checksum[15:8];
    end else if (fetch_ptr == CW'(3)) begin
      fetch_byte = reply_checksum[7:0];
    end else begin
      fetch_byte = ram_rd_data;
    end
  end

  icmp_er_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_msg_ram (
    .clk     (clk),
    .wr_en   (load_fire && store_ok),
    .wr_addr (pos[AW-1:0]),
    .wr_data (data_byte),
    .rd_en   (fetch_fire),
    .rd_addr (read_pointer[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Type and code are kept aside so the verdict needs no RAM read.
  always_ff @(posedge clk) begin
    if (load_fire && store_ok && (pos == CW'(0))) begin
      msg_type <= data_byte;
    end
    if (load_fire && store_ok && (pos == CW'(1))) begin
      msg_code <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      byte_count     <= '0;
      overflow       <= 1'b0;
      sum_all        <= '0;
      sum_body       <= '0;
      high_hold      <= '0;
      reply_pending  <= 1'b0;
      read_pointer   <= '0;
      reply_checksum <= '0;
      hold_to_ip     <= '0;
      hold_from_ip   <= '0;
      hold_to_mac    <= '0;
      fetch_ptr      <= '0;
      fetch_end      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (load_fire) begin
            reply_pending <= 1'b0;
            read_pointer  <= '0;
            if (!last_byte) begin
              byte_count <= count_next;
              overflow   <= overflow_next;
              sum_all    <= sum_all_next;
              sum_body   <= sum_body_next;
              high_hold  <= high_hold_next;
            end else begin
              hold_to_ip   <= sender_ip;
              hold_from_ip <= receiver_ip;
              hold_to_mac  <= sender_mac;
              out_valid    <= 1'b1;
              result_kind  <= KIND_VERDICT;
              verdict      <= verdict_next;
              reply_byte   <= 8'h00;
              reply_end    <= 1'b0;
              overflow     <= 1'b0;
              sum_all      <= '0;
              sum_body     <= '0;
              high_hold    <= '0;
              if (verdict_next == VERD_READY) begin
                // keep the length; it bounds the fetch
                byte_count     <= count_next;
                reply_checksum <= ~sum_body_next;
                reply_pending  <= 1'b1;
                reply_length   <= LEN_W'(count_next);
                reply_to_ip    <= sender_ip;
                reply_from_ip  <= receiver_ip;
                reply_to_mac   <= sender_mac;
              end else begin
                byte_count    <= '0;
                reply_length  <= '0;
                reply_to_ip   <= '0;
                reply_from_ip <= '0;
                reply_to_mac  <= '0;
              end
            end
          end else if (fetch_fire) begin
            state     <= S_READ;
            fetch_ptr <= read_pointer;
            fetch_end <= ptr_at_end;
            if (ptr_at_end) begin
              // last reply byte: back to an empty message
              reply_pending <= 1'b0;
              read_pointer  <= '0;
              byte_count    <= '0;
              overflow      <= 1'b0;
              sum_all       <= '0;
              sum_body      <= '0;
              high_hold     <= '0;
            end else begin
              read_pointer <= read_pointer + CW'(1);
            end
          end
        end
        S_READ: begin
          state         <= S_IDLE;
          out_valid     <= 1'b1;
          result_kind   <= KIND_BYTE;
          verdict       <= VERD_READY;
          reply_length  <= '0;
          reply_byte    <= fetch_byte;
          reply_end     <= fetch_end;
          reply_to_ip   <= hold_to_ip;
          reply_from_ip <= hold_from_ip;
          reply_to_mac  <= hold_to_mac;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_read_gives_byte, clk, rst, state == S_READ |=> out_valid && result_kind == KIND_BYTE)
  `ASSERT_PROP(a_pending_len_ok, clk, rst, reply_pending |-> byte_count >= CW'(MIN_BYTES) && !overflow)
  `ASSERT_PROP(a_ptr_in_range, clk, rst, reply_pending |-> read_pointer < byte_count)
  `ASSERT_PROP(a_reject_no_addr, clk, rst, out_valid && result_kind == KIND_VERDICT && verdict != VERD_READY |-> reply_to_ip == '0 && reply_to_mac == '0)
  `ASSERT_NEVER(a_ovf_only_full, clk, rst, overflow && byte_count != CW'(MAX_BYTES))

endmodule

`default_nettype wire
